@@ rtl/nti_pkg.sv @@
package nti_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned NAME_BYTES  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned NAME_WORD_W = 64;
  localparam int unsigned S_TDATA_W   = 160;
  localparam int unsigned M_TDATA_W   = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_LOOKUP     = 2'd1,
    MODE_UNREGISTER = 2'd2,
    MODE_INVALID    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_REGISTER,
    OP_LOOKUP,
    OP_UNREGISTER,
    OP_REJECT
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NO_NAME = 3'd2,
    ST_NO_ID   = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MATCH,
    B_COMMIT
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic commit;
  } back_stat_t;

endpackage

@@ rtl/nti_front.sv @@
module nti_front #(
  parameter int unsigned NAME_BYTES = nti_pkg::NAME_BYTES,
  localparam int unsigned NameW     = 8 * NAME_BYTES
) (
  input  logic [nti_pkg::MODE_W-1:0]      mode_i,
  input  logic [nti_pkg::NAME_WORD_W-1:0] name_low_i,
  input  logic [nti_pkg::NAME_WORD_W-1:0] name_high_i,
  input  logic [nti_pkg::ID_W-1:0]        service_id_i,
  output nti_pkg::cmd_t                   cmd_o,
  output logic [NameW-1:0]                name_o
);

  logic [2*nti_pkg::NAME_WORD_W-1:0] raw;
  logic [2*nti_pkg::NAME_WORD_W-1:0] canon;

  assign raw = {name_high_i, name_low_i};

  // A name ends at its first zero byte; everything after it is cleared.
  always_comb begin
    logic running;
    logic [7:0] b;
    running = 1'b1;
    canon   = '0;
    for (int i = 0; i < 2 * nti_pkg::NAME_WORD_W / 8; i++) begin
      b = (i < NAME_BYTES) ? raw[8*i +: 8] : 8'h00;
      if (running) begin
        canon[8*i +: 8] = b;
      end
      if (b == 8'h00) begin
        running = 1'b0;
      end
    end
  end

  assign name_o = canon[NameW-1:0];

  always_comb begin
    cmd_o.id = service_id_i;
    case (nti_pkg::mode_e'(mode_i))
      nti_pkg::MODE_REGISTER: begin
        cmd_o.op = (service_id_i != '0) ? nti_pkg::OP_REGISTER : nti_pkg::OP_REJECT;
      end
      nti_pkg::MODE_LOOKUP: begin
        cmd_o.op = nti_pkg::OP_LOOKUP;
      end
      nti_pkg::MODE_UNREGISTER: begin
        cmd_o.op = (service_id_i != '0) ? nti_pkg::OP_UNREGISTER : nti_pkg::OP_REJECT;
      end
      default: begin
        cmd_o.op = nti_pkg::OP_REJECT;
      end
    endcase
  end

endmodule

@@ rtl/nti_fifo.sv @@
module nti_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = nti_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/nti_back.sv @@
module nti_back #(
  parameter int unsigned SLOTS      = nti_pkg::SLOTS,
  parameter int unsigned NAME_BYTES = nti_pkg::NAME_BYTES,
  localparam int unsigned NameW     = 8 * NAME_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  nti_pkg::cmd_t                 cmd_i,
  input  logic [NameW-1:0]              name_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [nti_pkg::STATUS_W-1:0]  status_o,
  output logic [nti_pkg::ID_W-1:0]      found_id_o,
  output nti_pkg::back_stat_t           stat_o
);

  nti_pkg::back_state_e state_q, state_d;

  logic [nti_pkg::ID_W-1:0] slot_id_q   [SLOTS];
  logic [NameW-1:0]         slot_name_q [SLOTS];

  nti_pkg::cmd_t            cur_cmd_q;
  logic [NameW-1:0]         cur_name_q;

  logic [SLOTS-1:0]         free_vec_q;
  logic [SLOTS-1:0]         name_vec_q;
  logic [SLOTS-1:0]         id_vec_q;

  logic                     out_valid_q;
  nti_pkg::status_e         out_status_q;
  logic [nti_pkg::ID_W-1:0] out_id_q;

  logic                     out_free;
  logic                     commit;
  logic [SLOTS-1:0]         sel_vec;
  logic [SLOTS-1:0]         pick;
  nti_pkg::status_e         status;
  logic [nti_pkg::ID_W-1:0] found;

  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    commit  = 1'b0;
    case (state_q)
      nti_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = nti_pkg::B_MATCH;
        end
      end
      nti_pkg::B_MATCH: begin
        state_d = nti_pkg::B_COMMIT;
      end
      nti_pkg::B_COMMIT: begin
        if (out_free) begin
          commit = 1'b1;
          if (!empty_i) begin
            pop_o   = 1'b1;
            state_d = nti_pkg::B_MATCH;
          end else begin
            state_d = nti_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_d = nti_pkg::B_IDLE;
      end
    endcase
  end

  // The lowest set bit of the candidate vector picks the slot.
  always_comb begin
    case (cur_cmd_q.op)
      nti_pkg::OP_REGISTER:   sel_vec = free_vec_q;
      nti_pkg::OP_LOOKUP:     sel_vec = name_vec_q;
      nti_pkg::OP_UNREGISTER: sel_vec = id_vec_q;
      default:                sel_vec = '0;
    endcase
    pick  = sel_vec & (~sel_vec + 1'b1);
    found = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick[i] && cur_cmd_q.op == nti_pkg::OP_LOOKUP) begin
        found = found | slot_id_q[i];
      end
    end
    case (cur_cmd_q.op)
      nti_pkg::OP_REGISTER:   status = (pick != '0) ? nti_pkg::ST_OK : nti_pkg::ST_FULL;
      nti_pkg::OP_LOOKUP:     status = (pick != '0) ? nti_pkg::ST_OK : nti_pkg::ST_NO_NAME;
      nti_pkg::OP_UNREGISTER: status = (pick != '0) ? nti_pkg::ST_OK : nti_pkg::ST_NO_ID;
      default:                status = nti_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nti_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (pick[i]) begin
            if (cur_cmd_q.op == nti_pkg::OP_REGISTER) begin
              slot_id_q[i] <= cur_cmd_q.id;
            end else if (cur_cmd_q.op == nti_pkg::OP_UNREGISTER) begin
              slot_id_q[i] <= '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_cmd_q  <= cmd_i;
      cur_name_q <= name_i;
    end
    if (state_q == nti_pkg::B_MATCH) begin
      for (int i = 0; i < SLOTS; i++) begin
        free_vec_q[i] <= (slot_id_q[i] == '0);
        name_vec_q[i] <= (slot_id_q[i] != '0) && (slot_name_q[i] == cur_name_q);
        id_vec_q[i]   <= (slot_id_q[i] == cur_cmd_q.id);
      end
    end
    if (commit) begin
      out_status_q <= status;
      out_id_q     <= found;
      for (int i = 0; i < SLOTS; i++) begin
        if (pick[i] && cur_cmd_q.op == nti_pkg::OP_REGISTER) begin
          slot_name_q[i] <= cur_name_q;
        end
      end
    end
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_id_o    = out_id_q;
  assign stat_o.idle   = (state_q == nti_pkg::B_IDLE);
  assign stat_o.commit = commit;

endmodule

@@ rtl/name_to_id_table.sv @@
// Channel   Direction  Request fields (lowest bit up)
// s_axis    in         tdata: name_low, name_high, service_id; tuser: mode
// m_axis    out        tdata: status, found_id, zero fill
//
// The engine takes each request through two steps: a match step compares the name
// and id against every slot at once, and a commit step picks the lowest free or
// matching slot, updates it on a register or unregister, and writes the result.
// After reset every slot is free at once; there is no clearing pass.
// A two-deep queue lets requests be taken while the engine works. A result waits in
// the result register until it is taken, and meanwhile the engine holds the next
// request in its update step, so the queue fills and then holds off the input.
module name_to_id_table #(
  parameter int unsigned SLOTS      = nti_pkg::SLOTS,
  parameter int unsigned NAME_BYTES = nti_pkg::NAME_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // name_low [63:0], name_high [127:64], service_id [159:128]
  input  logic [nti_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // mode [1:0]
  input  logic [nti_pkg::MODE_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status [2:0], found_id [34:3], zero [39:35]
  output logic [nti_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned NameW = 8 * NAME_BYTES;
  localparam int unsigned QW    = $bits(nti_pkg::cmd_t) + NameW;

  nti_pkg::cmd_t            front_cmd;
  logic [NameW-1:0]         front_name;
  nti_pkg::cmd_t            back_cmd;
  logic [NameW-1:0]         back_name;
  logic                     q_full;
  logic                     q_empty;
  logic                     q_pop;
  logic [QW-1:0]            q_out;
  logic [nti_pkg::STATUS_W-1:0] status;
  logic [nti_pkg::ID_W-1:0] found_id;
  nti_pkg::back_stat_t      back_stat;

  nti_front #(
    .NAME_BYTES(NAME_BYTES)
  ) u_front (
    .mode_i      (s_axis_tuser_i),
    .name_low_i  (s_axis_tdata_i[63:0]),
    .name_high_i (s_axis_tdata_i[127:64]),
    .service_id_i(s_axis_tdata_i[159:128]),
    .cmd_o       (front_cmd),
    .name_o      (front_name)
  );

  nti_fifo #(
    .WIDTH(QW),
    .DEPTH(nti_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid_i),
    .data_i ({front_cmd, front_name}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  assign s_axis_tready_o = !q_full;
  assign back_cmd        = q_out[QW-1:NameW];
  assign back_name       = q_out[NameW-1:0];

  nti_back #(
    .SLOTS     (SLOTS),
    .NAME_BYTES(NAME_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .cmd_i      (back_cmd),
    .name_i     (back_name),
    .pop_o      (q_pop),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .status_o   (status),
    .found_id_o (found_id),
    .stat_o     (back_stat)
  );

  assign m_axis_tdata_o = {5'b00000, found_id, status};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !q_empty)
    else $error("Accepted request did not reach the queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.idle && !q_empty |=> !back_stat.idle)
    else $error("Engine stayed idle with a queued request.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.commit |=> m_axis_tvalid_o)
    else $error("Completed request gave no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && found_id != '0 |-> status == nti_pkg::ST_OK)
    else $error("Nonzero id returned with a failing status.");

endmodule
